@@ hdl/kse_pkg.sv @@
// Shared types, constants and the key-to-segment table for the keypad scan
// and seven-segment entry block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kse_pkg;

    localparam int DWELL_WIDTH_DEF = 16;  // default dwell counter width
    localparam int CFG_DWELL_W     = 16;  // width of the dwell registers
    localparam int SEG_W           = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int NUM_DIGITS      = 4;
    localparam int PRESS_CNT_W     = 3;

    localparam logic [CFG_DWELL_W-1:0] ROW_DWELL_RST = 16'd1600;
    localparam logic [CFG_DWELL_W-1:0] DIG1_DWELL_RST = 16'd4800;
    localparam logic [CFG_DWELL_W-1:0] DIG2_DWELL_RST = 16'd4800;
    localparam logic [CFG_DWELL_W-1:0] DIG3_DWELL_RST = 16'd6400;
    localparam logic [CFG_DWELL_W-1:0] DIG4_DWELL_RST = 16'd800;
    localparam logic [SEG_W-1:0]       BLANK_RST      = 8'h7F;

    // presses per entry before the display is wiped
    localparam logic [PRESS_CNT_W-1:0] PRESS_WRAP = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_DWELL  = 3'd0,
        CFG_DIG1_DWELL = 3'd1,
        CFG_DIG2_DWELL = 3'd2,
        CFG_DIG3_DWELL = 3'd3,
        CFG_DIG4_DWELL = 3'd4,
        CFG_BLANK      = 3'd5
    } t_cfg_idx;

    // one recorded key press handed to the digit store
    typedef struct packed {
        logic       valid;
        logic [3:0] code;
    } t_press;

    function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            4'd0:  seg = 8'h79;
            4'd1:  seg = 8'h24;
            4'd2:  seg = 8'h30;
            4'd3:  seg = 8'h08;
            4'd4:  seg = 8'h19;
            4'd5:  seg = 8'h12;
            4'd6:  seg = 8'h02;
            4'd7:  seg = 8'h03;
            4'd8:  seg = 8'h78;
            4'd9:  seg = 8'h00;
            4'd10: seg = 8'h10;
            4'd11: seg = 8'h46;
            4'd12: seg = 8'h92;
            4'd13: seg = 8'h40;
            4'd14: seg = 8'h09;
            default: seg = 8'h21;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

@@ hdl/kse_digits.sv @@
// Four-digit pattern store: shifts in a new key pattern per press and blanks
// the display on every fifth press. Depends on kse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kse_digits (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire kse_pkg::t_press            i_press,
    input  wire logic [kse_pkg::SEG_W-1:0]  i_blank,
    input  wire logic [1:0]                 i_rd_sel,
    output logic      [kse_pkg::SEG_W-1:0]  o_pattern
);

    logic [kse_pkg::SEG_W-1:0]       r_digits [kse_pkg::NUM_DIGITS];
    logic [kse_pkg::SEG_W-1:0]       n_digits [kse_pkg::NUM_DIGITS];
    logic [kse_pkg::PRESS_CNT_W-1:0] r_press_count;
    logic [kse_pkg::PRESS_CNT_W-1:0] n_press_count;
    logic [kse_pkg::PRESS_CNT_W-1:0] w_count_inc;

    assign w_count_inc = r_press_count + 1'b1;

    always_comb begin
        n_digits      = r_digits;
        n_press_count = r_press_count;
        if (i_press.valid) begin
            if (w_count_inc >= kse_pkg::PRESS_WRAP) begin
                n_press_count = '0;
                for (int k = 0; k < kse_pkg::NUM_DIGITS; k++) begin
                    n_digits[k] = i_blank;
                end
            end else begin
                n_press_count = w_count_inc;
                // press n only moves the first n digits
                for (int k = 1; k < kse_pkg::NUM_DIGITS; k++) begin
                    if (k < int'(w_count_inc)) begin
                        n_digits[k] = r_digits[k-1];
                    end
                end
                n_digits[0] = kse_pkg::seg_lookup(i_press.code);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_count <= '0;
            for (int k = 0; k < kse_pkg::NUM_DIGITS; k++) begin
                r_digits[k] <= kse_pkg::BLANK_RST;
            end
        end else begin
            r_press_count <= n_press_count;
            r_digits      <= n_digits;
        end
    end

    assign o_pattern = r_digits[i_rd_sel];

endmodule

`default_nettype wire

@@ hdl/keypad_scan_seven_segment_entry.sv @@
// Keypad scan and four-digit seven-segment entry, top level.
// Depends on kse_pkg and kse_digits.
//
// Usage: each transaction on the input channel (i_in_valid / o_in_ready)
// is one scan tick carrying the 4-bit column sample. Every accepted tick
// yields exactly one result transaction on the output channel
// (o_out_valid / i_out_ready): row drive, digit select, segment byte, and
// a key_accepted strobe with its key code.
// o_out_valid rises in the cycle after acceptance. Throughput is one tick
// per cycle while results are taken; the whole scan step runs between the
// sequencer state and output register, so ticks may follow back to back.
// The output register frees up in the cycle it is taken, so a new tick is
// accepted while a result is handed off. When the receiver stalls, the
// result is held and o_in_ready drops until it is taken.
// Reset (synchronous, active low) puts the sequencer in row phase 0,
// loads default dwell counts and blank pattern, and blanks all digits.
// Config writes (i_cfg_wr_en) take effect at once; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module keypad_scan_seven_segment_entry #(
    parameter int DWELL_WIDTH = kse_pkg::DWELL_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [3:0]                      i_column_sample,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [3:0]                      o_row_drive,
    output logic      [3:0]                      o_digit_select,
    output logic      [kse_pkg::SEG_W-1:0]       o_segments,
    output logic                                 o_key_accepted,
    output logic      [3:0]                      o_key_code,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [kse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [kse_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int DW    = kse_pkg::CFG_DWELL_W;
    localparam int EXT_W = ((DWELL_WIDTH > DW) ? DWELL_WIDTH : DW) + 1;
    localparam logic [EXT_W-1:0] DWELL_CAP = EXT_W'(1) << DWELL_WIDTH;

    // configuration
    logic [DW-1:0]             r_row_dwell;
    logic [DW-1:0]             r_dig_dwell [kse_pkg::NUM_DIGITS];
    logic [kse_pkg::SEG_W-1:0] r_blank;

    // sequencer state
    logic [2:0]                r_phase,          n_phase;
    logic [DWELL_WIDTH-1:0]    r_dwell,          n_dwell;
    logic                      r_row_checked,    n_row_checked;
    logic                      r_awaiting,       n_awaiting;
    logic [1:0]                r_held_col,       n_held_col;
    logic [3:0]                r_shown_sel,      n_shown_sel;
    logic [kse_pkg::SEG_W-1:0] r_shown_seg,      n_shown_seg;

    // output register
    logic                      r_out_valid;
    logic [3:0]                r_row_drive,      n_row_drive;
    logic                      r_key_acc;
    logic [3:0]                r_key_code;

    logic                      w_accept;
    logic                      w_display;
    logic [1:0]                w_sub;
    logic [DW-1:0]             w_dwell_reg;
    logic [EXT_W-1:0]          w_eff_dwell;
    logic [EXT_W-1:0]          w_dwell_next;
    logic                      w_dwell_done;
    logic                      w_one_hot;
    logic [1:0]                w_col_enc;
    logic [kse_pkg::SEG_W-1:0] w_pattern;
    kse_pkg::t_press           w_press;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_display  = r_phase[2];
    assign w_sub      = r_phase[1:0];

    // one dwell compare, shared by row and digit phases
    assign w_dwell_reg  = w_display ? r_dig_dwell[w_sub] : r_row_dwell;
    assign w_dwell_next = EXT_W'(r_dwell) + EXT_W'(1);

    always_comb begin
        w_eff_dwell = EXT_W'(w_dwell_reg);
        if (w_eff_dwell == '0) begin
            w_eff_dwell = EXT_W'(1);
        end else if (w_eff_dwell > DWELL_CAP) begin
            w_eff_dwell = DWELL_CAP;
        end
    end

    assign w_dwell_done = (w_dwell_next >= w_eff_dwell);

    always_comb begin
        w_one_hot = 1'b1;
        w_col_enc = 2'd0;
        unique case (i_column_sample)
            4'b0001: w_col_enc = 2'd0;
            4'b0010: w_col_enc = 2'd1;
            4'b0100: w_col_enc = 2'd2;
            4'b1000: w_col_enc = 2'd3;
            default: w_one_hot = 1'b0;
        endcase
    end

    kse_digits u_digits (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_press   (w_press),
        .i_blank   (r_blank),
        .i_rd_sel  (w_sub),
        .o_pattern (w_pattern)
    );

    always_comb begin
        n_phase       = r_phase;
        n_dwell       = r_dwell;
        n_row_checked = r_row_checked;
        n_awaiting    = r_awaiting;
        n_held_col    = r_held_col;
        n_shown_sel   = r_shown_sel;
        n_shown_seg   = r_shown_seg;
        w_press.valid = 1'b0;
        w_press.code  = 4'd0;
        n_row_drive   = 4'b1000;

        if (!w_display) begin
            n_row_drive = 4'b0001 << w_sub;
            if (!r_row_checked) begin
                // check tick: does not count toward the dwell
                n_row_checked = 1'b1;
                n_dwell       = '0;
                if (w_one_hot) begin
                    n_awaiting = 1'b1;
                    n_held_col = w_col_enc;
                end
            end else if (r_awaiting) begin
                if (i_column_sample != (4'b0001 << r_held_col)) begin
                    n_awaiting    = 1'b0;
                    n_dwell       = '0;
                    w_press.valid = 1'b1;
                    w_press.code  = {w_sub, r_held_col};
                end
            end else if (w_dwell_done) begin
                n_dwell       = '0;
                n_phase       = r_phase + 3'd1;
                n_row_checked = 1'b0;
            end else begin
                n_dwell = w_dwell_next[DWELL_WIDTH-1:0];
            end
        end else begin
            n_shown_sel = 4'b1000 >> w_sub;
            n_shown_seg = w_pattern;
            if (w_dwell_done) begin
                n_dwell       = '0;
                n_phase       = r_phase + 3'd1;
                n_row_checked = 1'b0;
            end else begin
                n_dwell = w_dwell_next[DWELL_WIDTH-1:0];
            end
        end

        if (!w_accept) begin
            w_press.valid = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_dwell    <= kse_pkg::ROW_DWELL_RST;
            r_dig_dwell[0] <= kse_pkg::DIG1_DWELL_RST;
            r_dig_dwell[1] <= kse_pkg::DIG2_DWELL_RST;
            r_dig_dwell[2] <= kse_pkg::DIG3_DWELL_RST;
            r_dig_dwell[3] <= kse_pkg::DIG4_DWELL_RST;
            r_blank        <= kse_pkg::BLANK_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                kse_pkg::CFG_ROW_DWELL:  r_row_dwell    <= i_cfg_wdata[DW-1:0];
                kse_pkg::CFG_DIG1_DWELL: r_dig_dwell[0] <= i_cfg_wdata[DW-1:0];
                kse_pkg::CFG_DIG2_DWELL: r_dig_dwell[1] <= i_cfg_wdata[DW-1:0];
                kse_pkg::CFG_DIG3_DWELL: r_dig_dwell[2] <= i_cfg_wdata[DW-1:0];
                kse_pkg::CFG_DIG4_DWELL: r_dig_dwell[3] <= i_cfg_wdata[DW-1:0];
                kse_pkg::CFG_BLANK:      r_blank <= i_cfg_wdata[kse_pkg::SEG_W-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_dwell       <= '0;
            r_row_checked <= 1'b0;
            r_awaiting    <= 1'b0;
            r_held_col    <= '0;
            r_shown_sel   <= '0;
            r_shown_seg   <= '0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_dwell       <= n_dwell;
            r_row_checked <= n_row_checked;
            r_awaiting    <= n_awaiting;
            r_held_col    <= n_held_col;
            r_shown_sel   <= n_shown_sel;
            r_shown_seg   <= n_shown_seg;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row_drive <= n_row_drive;
            r_key_acc   <= w_press.valid;
            r_key_code  <= w_press.code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_drive    = r_row_drive;
    assign o_digit_select = r_shown_sel;
    assign o_segments     = r_shown_seg;
    assign o_key_accepted = r_key_acc;
    assign o_key_code     = r_key_code;

endmodule

`default_nettype wire
